FILE: rtl/core/lvcc_pkg.sv
package lvcc_pkg;

  // World coordinates are fixed by the word layout on both channels.
  localparam int COORD_BITS = 24;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int CFG_DATA_BITS = 48;
  localparam int CFG_INDEX_BITS = 3;

  // Reset value of the half view angle register.
  localparam int HALF_ANGLE_RESET = 7721;

  // Cosine series constants; pi and one are in Q30.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam int COS_TERMS = 5;
  // Cosine unit register stages: angle fold, square, three stages per term, last product, round.
  localparam int COS_LAT = 2 + 3 * COS_TERMS + 2;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CAMERA_X        = 3'd0,
    REG_CAMERA_Y        = 3'd1,
    REG_CAMERA_Z        = 3'd2,
    REG_VIEW_DIRECTION  = 3'd3,
    REG_HALF_VIEW_ANGLE = 3'd4,
    REG_MAX_DISTANCE    = 3'd5,
    REG_CULL_OUTSIDE    = 3'd6
  } cfg_reg_t;

  // Result cause codes.
  typedef enum logic [2:0] {
    CAUSE_INSIDE   = 3'd0,
    CAUSE_IN_CONE  = 3'd1,
    CAUSE_TOO_FAR  = 3'd2,
    CAUSE_OUTSIDE  = 3'd3,
    CAUSE_CONE_OFF = 3'd4
  } cause_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] light_x;
    logic signed [COORD_BITS-1:0] light_y;
    logic signed [COORD_BITS-1:0] light_z;
    logic        [COORD_BITS-1:0] light_radius;
  } lvcc_in_t;

  typedef struct packed {
    logic       visible;
    logic [2:0] cause;
  } lvcc_out_t;

  // Divisors of the nested series terms, innermost first.
  function automatic int cos_divisor(input int i);
    int d;
    case (i)
      0:       d = 132;
      1:       d = 90;
      2:       d = 56;
      3:       d = 30;
      default: d = 12;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/light_view_cone_cull.sv
// Channel   Direction  Word        Handshake
// cfg       in         cfg_data    cfg_write, cfg_index (no wait)
// in        in         in_data     in_valid / in_ready
// out       out        out_data    out_valid / out_ready
//
// One word enters per cycle unless the output stalls; the pipeline depth is set by
// the square root (one root bit per stage), the widening divide (one quotient bit
// per stage) and the cosine series (three stages per term).
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
module light_view_cone_cull import lvcc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lvcc_in_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lvcc_out_t                 out_data
);

  localparam int C    = COORD_BITS;
  localparam int F    = ANGLE_FRAC_BITS;
  localparam int DW   = C + 1;
  localparam int SW   = 2 * C + 2;
  localparam int PW   = C + 17;
  localparam int DOTW = C + 19;
  localparam int RW   = C + 2;
  localparam int QW   = F + 1;
  localparam int AW   = F + 2;

  localparam int S_SQ    = 1;
  localparam int S_SUM   = 2;
  localparam int S_ROOT  = 3;
  localparam int S_DEC   = C + 4;
  localparam int S_DIV   = C + 5;
  localparam int S_ANG   = C + 6 + F;
  localparam int S_PROD  = S_ANG + COS_LAT + 1;
  localparam int NST     = S_PROD + 2;

  localparam logic [AW:0] PI_Q = (AW+1)'((PI_Q30 + (64'd1 << (29 - F))) >> (30 - F));

  typedef struct packed {
    logic signed [C:0]      dx;
    logic signed [C:0]      dy;
    logic signed [C:0]      dz;
    logic [C-1:0]           radius;
    logic [2*C-1:0]         sqx;
    logic [2*C-1:0]         sqy;
    logic [2*C-1:0]         sqz;
    logic signed [PW-1:0]   px;
    logic signed [PW-1:0]   py;
    logic signed [PW-1:0]   pz;
    logic signed [DOTW-1:0] dot;
    logic                   d2z;
    logic [SW-1:0]          op;
    logic [SW-1:0]          res;
    logic [DW-1:0]          dist_len;
    logic                   far;
    logic                   in_radius;
    logic [RW-1:0]          rem;
    logic [QW-1:0]          quo;
    logic [AW-1:0]          ang;
    logic signed [DOTW-1:0] prod;
    logic                   visible;
    logic [2:0]             cause;
  } pipe_t;

  logic signed [C-1:0] camera_x;
  logic signed [C-1:0] camera_y;
  logic signed [C-1:0] camera_z;
  logic [47:0]         view_direction;
  logic [AW-1:0]       half_view_angle;
  logic [DW-1:0]       max_distance;
  logic                cull_outside_view;

  pipe_t            st  [NST];
  pipe_t            nxt [NST];
  logic [NST-1:0]   vld;
  logic             adv;
  logic signed [15:0] ct;

  function automatic logic [C-1:0] mag(input logic signed [C:0] v);
    logic [C:0] m;
    m = v[C] ? -v : v;
    return m[C-1:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x          <= '0;
      camera_y          <= '0;
      camera_z          <= '0;
      view_direction    <= '0;
      half_view_angle   <= AW'(HALF_ANGLE_RESET);
      max_distance      <= '0;
      cull_outside_view <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CAMERA_X:        camera_x          <= cfg_data[C-1:0];
        REG_CAMERA_Y:        camera_y          <= cfg_data[C-1:0];
        REG_CAMERA_Z:        camera_z          <= cfg_data[C-1:0];
        REG_VIEW_DIRECTION:  view_direction    <= cfg_data[47:0];
        REG_HALF_VIEW_ANGLE: half_view_angle   <= cfg_data[AW-1:0];
        REG_MAX_DISTANCE:    max_distance      <= cfg_data[DW-1:0];
        REG_CULL_OUTSIDE:    cull_outside_view <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is empty or being taken.
  assign adv       = ~vld[NST-1] | out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NST-1];
  assign out_data  = '{visible: st[NST-1].visible, cause: st[NST-1].cause};

  // Entry stage: offsets from the camera.
  always_comb begin
    nxt[0]        = st[0];
    nxt[0].dx     = (C+1)'(in_data.light_x) - (C+1)'(camera_x);
    nxt[0].dy     = (C+1)'(in_data.light_y) - (C+1)'(camera_y);
    nxt[0].dz     = (C+1)'(in_data.light_z) - (C+1)'(camera_z);
    nxt[0].radius = in_data.light_radius;
  end

  for (genvar k = 1; k < NST; k++) begin : g_stage
    if (k == S_SQ) begin : g_sq
      // Squares of the offsets and the terms of the dot product.
      always_comb begin
        nxt[k]     = st[k-1];
        nxt[k].sqx = mag(st[k-1].dx) * mag(st[k-1].dx);
        nxt[k].sqy = mag(st[k-1].dy) * mag(st[k-1].dy);
        nxt[k].sqz = mag(st[k-1].dz) * mag(st[k-1].dz);
        nxt[k].px  = st[k-1].dx * $signed(view_direction[47:32]);
        nxt[k].py  = st[k-1].dy * $signed(view_direction[31:16]);
        nxt[k].pz  = st[k-1].dz * $signed(view_direction[15:0]);
        nxt[k].d2z = (st[k-1].dx == '0) && (st[k-1].dy == '0) && (st[k-1].dz == '0);
      end
    end else if (k == S_SUM) begin : g_sum
      // Squared distance and dot product.
      always_comb begin
        nxt[k]     = st[k-1];
        nxt[k].op  = SW'(st[k-1].sqx) + SW'(st[k-1].sqy) + SW'(st[k-1].sqz);
        nxt[k].res = '0;
        nxt[k].dot = DOTW'(st[k-1].px) + DOTW'(st[k-1].py) + DOTW'(st[k-1].pz);
      end
    end else if (k >= S_ROOT && k < S_DEC) begin : g_root
      // One root bit per stage, highest first.
      localparam int J = k - S_ROOT;
      localparam logic [SW-1:0] BIT = SW'(1) << (2 * (C - J));
      always_comb begin
        logic [SW-1:0] trial;
        nxt[k] = st[k-1];
        trial  = st[k-1].res + BIT;
        if (st[k-1].op >= trial) begin
          nxt[k].op  = st[k-1].op - trial;
          nxt[k].res = (st[k-1].res >> 1) + BIT;
        end else begin
          nxt[k].res = st[k-1].res >> 1;
        end
      end
    end else if (k == S_DEC) begin : g_dec
      // Distance tests; a nonzero remainder means the distance is not exact.
      always_comb begin
        logic [DW-1:0] d;
        logic          exact;
        d                = st[k-1].res[DW-1:0];
        exact            = (st[k-1].op == '0);
        nxt[k]           = st[k-1];
        nxt[k].dist_len  = d;
        nxt[k].far       = (max_distance != '0) &&
                           ((d > max_distance) || ((d == max_distance) && !exact));
        nxt[k].in_radius = st[k-1].d2z || (d < DW'(st[k-1].radius));
        nxt[k].rem       = RW'(st[k-1].radius);
        nxt[k].quo       = '0;
      end
    end else if (k >= S_DIV && k < S_ANG) begin : g_div
      // Widening angle, one quotient bit per stage.
      localparam int J = k - S_DIV;
      always_comb begin
        logic [RW-1:0] r2;
        logic          qb;
        nxt[k] = st[k-1];
        r2     = (J == 0) ? st[k-1].rem : st[k-1].rem << 1;
        qb     = (r2 >= RW'(st[k-1].dist_len));
        nxt[k].rem = qb ? r2 - RW'(st[k-1].dist_len) : r2;
        nxt[k].quo = {st[k-1].quo[QW-2:0], qb};
      end
    end else if (k == S_ANG) begin : g_ang
      // Cone half angle plus widening, saturated at pi.
      always_comb begin
        logic [AW:0] sum;
        sum        = (AW+1)'(half_view_angle) + (AW+1)'(st[k-1].quo);
        nxt[k]     = st[k-1];
        nxt[k].ang = (sum > PI_Q) ? PI_Q[AW-1:0] : sum[AW-1:0];
      end
    end else if (k == S_PROD) begin : g_prod
      // Cosine scaled by the distance.
      always_comb begin
        nxt[k]      = st[k-1];
        nxt[k].prod = DOTW'(ct * $signed({1'b0, st[k-1].dist_len}));
      end
    end else if (k == NST - 1) begin : g_out
      // Final decision in priority order.
      always_comb begin
        nxt[k] = st[k-1];
        if (st[k-1].far) begin
          nxt[k].visible = 1'b0;
          nxt[k].cause   = CAUSE_TOO_FAR;
        end else if (st[k-1].in_radius) begin
          nxt[k].visible = 1'b1;
          nxt[k].cause   = CAUSE_INSIDE;
        end else if (!cull_outside_view) begin
          nxt[k].visible = 1'b1;
          nxt[k].cause   = CAUSE_CONE_OFF;
        end else if (st[k-1].dot < st[k-1].prod) begin
          nxt[k].visible = 1'b0;
          nxt[k].cause   = CAUSE_OUTSIDE;
        end else begin
          nxt[k].visible = 1'b1;
          nxt[k].cause   = CAUSE_IN_CONE;
        end
      end
    end else begin : g_copy
      // Delay stage that keeps the word aligned with the cosine unit.
      always_comb begin
        nxt[k] = st[k-1];
      end
    end
  end

  // Stage registers and their valid bits.
  for (genvar k = 0; k < NST; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) begin
        st[k] <= nxt[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
      end
    end
  end

  lvcc_cos #(
    .ANGLE_FRAC_BITS(F)
  ) u_cos (
    .clk (clk),
    .en  (adv),
    .ang (st[S_ANG].ang),
    .ct  (ct)
  );

endmodule

FILE: rtl/core/lvcc_cos.sv
module lvcc_cos import lvcc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ANGLE_FRAC_BITS+1:0]   ang,
  output logic signed [15:0]           ct
);

  localparam logic [32:0] PI30 = PI_Q30[32:0];
  localparam logic [32:0] PI30_HALF = 33'(PI_Q30 / 2);
  localparam logic [30:0] ONE = ONE_Q30[30:0];

  logic [30:0] y0;
  logic        neg0;
  logic [31:0] y2_1;
  logic        neg1;

  logic [31:0] xm  [COS_TERMS];
  logic [31:0] y2m [COS_TERMS];
  logic        negm[COS_TERMS];
  logic [31:0] qe  [COS_TERMS];
  logic [31:0] xr  [COS_TERMS];
  logic [31:0] y2r [COS_TERMS];
  logic        negr[COS_TERMS];
  logic [30:0] tt  [COS_TERMS];
  logic [31:0] y2t [COS_TERMS];
  logic        negt[COS_TERMS];

  logic [31:0] xf;
  logic        negf;

  // Fold the angle onto the first quadrant.
  always_ff @(posedge clk) begin
    logic [32:0] a30;
    a30 = 33'(ang) << (30 - ANGLE_FRAC_BITS);
    if (en) begin
      if (a30 > PI30_HALF) begin
        neg0 <= 1'b1;
        y0   <= (a30 >= PI30) ? 31'd0 : 31'(PI30 - a30);
      end else begin
        neg0 <= 1'b0;
        y0   <= a30[30:0];
      end
    end
  end

  // Square of the folded angle in Q30.
  always_ff @(posedge clk) begin
    logic [61:0] sq;
    sq = 62'(y0) * 62'(y0);
    if (en) begin
      y2_1 <= sq[61:30];
      neg1 <= neg0;
    end
  end

  // One nested term per three stages: multiply, reciprocal estimate, correction.
  for (genvar i = 0; i < COS_TERMS; i++) begin : g_term
    localparam int DIV = cos_divisor(i);
    localparam logic [63:0] RECIP = (64'd1 << 33) / DIV;

    logic [30:0] t_in;
    logic [31:0] y2_in;
    logic        neg_in;

    if (i == 0) begin : g_first
      assign t_in   = ONE;
      assign y2_in  = y2_1;
      assign neg_in = neg1;
    end else begin : g_next
      assign t_in   = tt[i-1];
      assign y2_in  = y2t[i-1];
      assign neg_in = negt[i-1];
    end

    always_ff @(posedge clk) begin
      logic [62:0] pr;
      pr = 63'(y2_in) * 63'(t_in);
      if (en) begin
        xm[i]   <= pr[61:30];
        y2m[i]  <= y2_in;
        negm[i] <= neg_in;
      end
    end

    always_ff @(posedge clk) begin
      logic [61:0] pr;
      pr = 62'(xm[i]) * 62'(RECIP[29:0]);
      if (en) begin
        qe[i]   <= 32'(pr[61:33]);
        xr[i]   <= xm[i];
        y2r[i]  <= y2m[i];
        negr[i] <= negm[i];
      end
    end

    // The estimate is at most one low; the remainder tells.
    always_ff @(posedge clk) begin
      logic [31:0] rem;
      logic [31:0] q;
      rem = xr[i] - 32'(qe[i] * 32'(DIV));
      q   = (rem >= 32'(DIV)) ? qe[i] + 32'd1 : qe[i];
      if (en) begin
        tt[i]   <= ONE - q[30:0];
        y2t[i]  <= y2r[i];
        negt[i] <= negr[i];
      end
    end
  end

  // Last product of the series.
  always_ff @(posedge clk) begin
    logic [62:0] pr;
    pr = 63'(y2t[COS_TERMS-1]) * 63'(tt[COS_TERMS-1]);
    if (en) begin
      xf   <= pr[61:30];
      negf <= negt[COS_TERMS-1];
    end
  end

  // Halve, subtract from one, round to Q1.14, cap and restore the sign.
  always_ff @(posedge clk) begin
    logic [30:0] p;
    logic [30:0] c;
    logic [31:0] cr;
    logic [15:0] c14;
    p   = xf[31:1];
    c   = (ONE > p) ? ONE - p : 31'd0;
    cr  = 32'(c) + 32'd32768;
    c14 = cr[31:16];
    if (c14 > 16'd16384) begin
      c14 = 16'd16384;
    end
    if (en) begin
      ct <= negf ? -$signed(c14) : $signed(c14);
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lvcc_pkg::*;

  localparam int AFB = ANGLE_FRAC_BITS_DEF;
  localparam int LATENCY = 65;
  localparam logic [63:0] PI_ANGLE =
    (PI_Q30 + (64'd1 << (29 - AFB))) >> (30 - AFB);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  lvcc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lvcc_out_t out_data;

  // Camera settings as the predictor sees them.
  logic signed [23:0] cam_x, cam_y, cam_z;
  logic [47:0] view_dir;
  logic [14:0] half_angle;
  logic [24:0] max_dist;
  logic cull_on;

  lvcc_in_t light_queue[$];
  lvcc_out_t verdict_queue[$];
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_off = 0;

  light_view_cone_cull i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Cosine of an angle in Q13 radians, result signed Q1.14.
  function automatic longint cone_cosine(input logic [63:0] a);
    logic [63:0] a30, y, y2, t, p, c, c14;
    logic [63:0] divs[5];
    bit neg;
    divs = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12};
    a30 = a << (30 - AFB);
    neg = 0;
    y = a30;
    if (a30 > PI_Q30 / 2) begin
      neg = 1;
      y = (a30 >= PI_Q30) ? 64'd0 : PI_Q30 - a30;
    end
    y2 = (y * y) >> 30;
    t = ONE_Q30;
    for (int i = 0; i < 5; i++) t = ONE_Q30 - ((y2 * t) >> 30) / divs[i];
    p = ((y2 * t) >> 30) / 2;
    c = (ONE_Q30 > p) ? ONE_Q30 - p : 64'd0;
    c14 = (c + (64'd1 << 15)) >> 16;
    if (c14 > 64'd16384) c14 = 64'd16384;
    return neg ? -longint'(c14) : longint'(c14);
  endfunction

  // Decides whether one light stays loaded for the current camera.
  function automatic lvcc_out_t light_verdict(input lvcc_in_t l);
    longint dx, dy, dz, dot, ct, fx, fy, fz;
    logic [127:0] d2, root, cand;
    logic [63:0] dist_len, widen, ang, radius;
    lvcc_out_t v;
    dx = longint'(l.light_x) - longint'(cam_x);
    dy = longint'(l.light_y) - longint'(cam_y);
    dz = longint'(l.light_z) - longint'(cam_z);
    radius = {40'd0, l.light_radius};
    d2 = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
    root = 0;
    for (int b = 34; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= d2) root = cand;
    end
    dist_len = root[63:0];
    if (max_dist != 0 && (dist_len > max_dist ||
        (dist_len == max_dist && root * root != d2))) begin
      v.visible = 1'b0; v.cause = CAUSE_TOO_FAR;
    end else if (d2 == 0 || dist_len < radius) begin
      v.visible = 1'b1; v.cause = CAUSE_INSIDE;
    end else if (!cull_on) begin
      v.visible = 1'b1; v.cause = CAUSE_CONE_OFF;
    end else begin
      fx = longint'($signed(view_dir[47:32]));
      fy = longint'($signed(view_dir[31:16]));
      fz = longint'($signed(view_dir[15:0]));
      dot = dx * fx + dy * fy + dz * fz;
      widen = (radius << AFB) / dist_len;
      ang = {49'd0, half_angle} + widen;
      if (ang > PI_ANGLE) ang = PI_ANGLE;
      ct = cone_cosine(ang);
      if (dot < ct * longint'(dist_len)) begin
        v.visible = 1'b0; v.cause = CAUSE_OUTSIDE;
      end else begin
        v.visible = 1'b1; v.cause = CAUSE_IN_CONE;
      end
    end
    return v;
  endfunction

  // Driver: offers pending words with random gaps.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        verdict_queue.push_back(light_verdict(in_data));
        void'(light_queue.pop_front());
        in_gap <= gap_len();
        if (light_queue.size() > 0 && gap_len() == 0) begin
          in_data <= light_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (light_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= light_queue[0];
        end
      end
    end
  end

  // Monitor: compares each result word and stalls the receiver at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (verdict_queue.size() == 0) report("result word with nothing expected");
        else begin
          if (out_data.visible !== verdict_queue[0].visible)
            report($sformatf("visible %0b, expected %0b", out_data.visible,
                             verdict_queue[0].visible));
          if (out_data.cause !== verdict_queue[0].cause)
            report($sformatf("cause %0d, expected %0d", out_data.cause,
                             verdict_queue[0].cause));
          void'(verdict_queue.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap <= gap_len();
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_CAMERA_X:        cam_x = val[23:0];
      REG_CAMERA_Y:        cam_y = val[23:0];
      REG_CAMERA_Z:        cam_z = val[23:0];
      REG_VIEW_DIRECTION:  view_dir = val;
      REG_HALF_VIEW_ANGLE: half_angle = val[14:0];
      REG_MAX_DISTANCE:    max_dist = val[24:0];
      REG_CULL_OUTSIDE:    cull_on = val[0];
      default: ;
    endcase
  endtask

  // Waits for every expected result plus the pipeline depth.
  task automatic drain();
    while (light_queue.size() > 0 || in_valid || verdict_queue.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_dir_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r < 6) return 16'($urandom_range(0, 32767) - 16384);
    return 16'($urandom);
  endfunction

  // Light around the camera, ahead or behind, sometimes anywhere, with random radius scale.
  function automatic lvcc_in_t rand_light();
    lvcc_in_t l;
    int span, r;
    r = $urandom_range(0, 9);
    span = (r < 5) ? 2000 : (r < 8) ? 200000 : 8388607;
    l.light_x = 24'(cam_x + $signed($urandom_range(0, 2 * span)) - span);
    l.light_y = 24'(cam_y + $signed($urandom_range(0, 2 * span)) - span);
    l.light_z = 24'(cam_z + $signed($urandom_range(0, 2 * span)) - span);
    r = $urandom_range(0, 9);
    if (r < 2) begin
      l.light_x = 24'($urandom); l.light_y = 24'($urandom); l.light_z = 24'($urandom);
    end
    r = $urandom_range(0, 9);
    l.light_radius = (r < 6) ? 24'($urandom_range(0, span / 2)) :
                     (r < 9) ? 24'($urandom_range(0, 3000)) : 24'($urandom);
    return l;
  endfunction

  function automatic lvcc_in_t mk(input int x, y, z, input logic [23:0] r);
    lvcc_in_t l;
    l.light_x = 24'(x); l.light_y = 24'(y); l.light_z = 24'(z); l.light_radius = r;
    return l;
  endfunction

  initial begin
    cam_x = 0; cam_y = 0; cam_z = 0; view_dir = 0;
    half_angle = 15'(HALF_ANGLE_RESET); max_dist = 0; cull_on = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under reset settings, then with the cone test on, then with extreme settings.
    light_queue.push_back(mk(0, 0, 0, 0));
    light_queue.push_back(mk(8388607, 8388607, 8388607, 24'hffffff));
    light_queue.push_back(mk(-8388608, -8388608, -8388608, 0));
    light_queue.push_back(mk(3, 4, 0, 5));
    light_queue.push_back(mk(3, 4, 0, 6));
    drain();
    write_reg(REG_VIEW_DIRECTION, {16'd16384, 16'd0, 16'd0});
    write_reg(REG_CULL_OUTSIDE, 48'd1);
    write_reg(REG_MAX_DISTANCE, 48'd5);
    light_queue.push_back(mk(3, 4, 0, 0));
    light_queue.push_back(mk(3, 4, 1, 0));
    light_queue.push_back(mk(0, 0, 0, 0));
    light_queue.push_back(mk(-3, -4, 0, 0));
    drain();
    write_reg(REG_MAX_DISTANCE, 48'h1ffffff);
    light_queue.push_back(mk(100, 0, 0, 1));
    light_queue.push_back(mk(-100, 0, 0, 1));
    light_queue.push_back(mk(0, 100, 0, 1));
    light_queue.push_back(mk(0, 100, 0, 24'hffffff));
    light_queue.push_back(mk(-8388608, 8388607, -8388608, 3));
    light_queue.push_back(mk(100, 100, 0, 0));
    drain();
    write_reg(REG_HALF_VIEW_ANGLE, 48'h7fff);
    write_reg(REG_VIEW_DIRECTION, 48'd0);
    write_reg(REG_CAMERA_X, 48'h800000);
    write_reg(REG_CAMERA_Y, 48'h7fffff);
    write_reg(REG_CAMERA_Z, 48'h800000);
    write_reg(cfg_reg_t'(3'd7), 48'hffff_ffff_ffff);
    light_queue.push_back(mk(8388607, -8388608, 8388607, 0));
    light_queue.push_back(mk(-8388600, 8388600, -8388608, 2));
    drain();
    write_reg(REG_HALF_VIEW_ANGLE, 48'd0);

    // Random phases with new camera settings each time.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CAMERA_X, 48'($urandom));
      write_reg(REG_CAMERA_Y, 48'($urandom));
      write_reg(REG_CAMERA_Z, 48'($urandom));
      write_reg(REG_VIEW_DIRECTION, {rand_dir_comp(), rand_dir_comp(), rand_dir_comp()});
      write_reg(REG_HALF_VIEW_ANGLE, (ph == 1) ? 48'd25736 :
                (ph == 2) ? 48'd0 : 48'($urandom_range(0, 32767)));
      write_reg(REG_MAX_DISTANCE, (ph % 3 == 0) ? 48'd0 :
                (ph == 7) ? 48'h1ffffff : 48'($urandom_range(0, 300000)));
      write_reg(REG_CULL_OUTSIDE, (ph == 4) ? 48'd0 : 48'd1);
      if (ph == 3) hold_off = 300;
      for (int k = 0; k < 80; k++) light_queue.push_back(rand_light());
      drain();
    end

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
